/* rtl/core/brp_pkg.sv */
`default_nettype none
package brp_pkg;

    localparam int VALUE_W  = 31;
    localparam int PICKED_W = 30;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_BUILD = 2'd1;
    localparam logic [1:0] MODE_PICK  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [1:0] STATUS_NOT_BUILT = 2'd3;

    // register index of range_size
    localparam logic REG_RANGE_SIZE = 1'b0;

    typedef struct packed {
        logic [1:0]         mode;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [PICKED_W-1:0] picked;
        logic [1:0]          status;
    } rsp_t;

endpackage
`default_nettype wire

/* rtl/core/brp_ram.sv */
`default_nettype none
module brp_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/brp_divider.sv */
`default_nettype none
// restoring remainder, one dividend bit per cycle
module brp_divider (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [brp_pkg::VALUE_W-1:0]    dividend,
    input  wire logic [brp_pkg::PICKED_W-1:0]   divisor,
    output logic                                done,
    output logic      [brp_pkg::PICKED_W-1:0]   remainder
);

    localparam int CW = $clog2(brp_pkg::VALUE_W + 1);

    logic [brp_pkg::VALUE_W-1:0]  dvd_reg;
    logic [brp_pkg::PICKED_W-1:0] dsr_reg;
    logic [brp_pkg::PICKED_W-1:0] rem_reg;
    logic [CW-1:0]                cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [brp_pkg::VALUE_W-1:0]  trial;
    logic [brp_pkg::VALUE_W-1:0]  diff;

    assign trial = {rem_reg, dvd_reg[brp_pkg::VALUE_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            dsr_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(brp_pkg::VALUE_W);
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (trial >= {1'b0, dsr_reg})
                begin
                    rem_reg <= diff[brp_pkg::PICKED_W-1:0];
                end
                else
                begin
                    rem_reg <= trial[brp_pkg::PICKED_W-1:0];
                end
                dvd_reg <= {dvd_reg[brp_pkg::VALUE_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

/* rtl/core/blacklist_remap_random_pick_unit.sv */
`default_nettype none
// Random pick over 0..range_size-1 that never returns an excluded value, by
// remapping. Each item gives exactly one result item. A load scans the stored
// table once for a duplicate. A pick runs a remainder unit, then scans the
// table for the reduced draw and, on a hit, reads its remap target. A build
// walks the table and, for each entry below the new bound, scans the table
// again for every candidate target. All scans are paced by the single read
// port of the excluded-value memory, one entry per cycle. Tables hold no
// reset state: only entries below the fill count are ever read. A new item
// is taken only once the previous result has been taken.
module blacklist_remap_random_pick_unit #(
    parameter int MAX_EXCLUDED = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // item input
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire brp_pkg::req_t      req,
    // result output
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output brp_pkg::rsp_t           rsp,
    // register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    localparam int AW    = (MAX_EXCLUDED > 1) ? $clog2(MAX_EXCLUDED) : 1;
    localparam int CNT_W = $clog2(MAX_EXCLUDED + 1);
    localparam int PW    = brp_pkg::PICKED_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_SCAN,
        ST_DIV,
        ST_PK_SCAN,
        ST_PK_RD,
        ST_BO_RD,
        ST_BO_CHK,
        ST_BI_SCAN
    } state_t;

    state_t           state_reg;
    logic [PW-1:0]    range_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PW-1:0]    bound_reg;
    logic             built_reg;
    logic [PW-1:0]    w_reg;
    logic [CNT_W-1:0] bidx_reg;
    logic [CNT_W-1:0] scan_idx_reg;
    logic             chk_vld_reg;
    logic [AW-1:0]    chk_idx_reg;
    logic [PW-1:0]    key_reg;
    logic             out_valid_reg;
    logic [PW-1:0]    out_picked_reg;
    logic [1:0]       out_status_reg;

    logic             accept;
    logic             cfg_wr;
    logic             scan_hit;
    logic             scan_can_issue;
    logic             scan_miss;
    logic             ev_we;
    logic [AW-1:0]    ev_waddr;
    logic [AW-1:0]    ev_raddr;
    logic [PW-1:0]    ev_rdata;
    logic             rm_we;
    logic [PW-1:0]    rm_rdata;
    logic             div_start;
    logic             div_done;
    logic [PW-1:0]    div_rem;

    assign req_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept    = req_valid && req_ready;
    assign cfg_wr    = psel && penable && pwrite && pready;

    // scan of the excluded-value table: one read issued per cycle, the data
    // of the previous read compared against the key
    assign scan_hit       = chk_vld_reg && (ev_rdata == key_reg);
    assign scan_can_issue = scan_idx_reg < count_reg;
    assign scan_miss      = !chk_vld_reg && !scan_can_issue;

    always_comb
    begin
        ev_raddr = scan_idx_reg[AW-1:0];
        if (state_reg == ST_BO_RD)
        begin
            ev_raddr = bidx_reg[AW-1:0];
        end
    end

    assign ev_we     = (state_reg == ST_LD_SCAN) && scan_miss;
    assign ev_waddr  = count_reg[AW-1:0];
    assign rm_we     = (state_reg == ST_BI_SCAN) && scan_miss;
    assign div_start = accept && (req.mode == brp_pkg::MODE_PICK) && built_reg
                       && (bound_reg != '0);

    brp_ram #(.WIDTH(PW), .DEPTH(MAX_EXCLUDED), .AW(AW)) u_excluded (
        .clk   (clk),
        .we    (ev_we),
        .waddr (ev_waddr),
        .wdata (key_reg),
        .raddr (ev_raddr),
        .rdata (ev_rdata)
    );

    // remap target per excluded entry, written by the build
    brp_ram #(.WIDTH(PW), .DEPTH(MAX_EXCLUDED), .AW(AW)) u_remap (
        .clk   (clk),
        .we    (rm_we),
        .waddr (bidx_reg[AW-1:0]),
        .wdata (w_reg),
        .raddr (chk_idx_reg),
        .rdata (rm_rdata)
    );

    brp_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (req.value),
        .divisor   (bound_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            range_reg      <= PW'(1);
            count_reg      <= '0;
            bound_reg      <= '0;
            built_reg      <= 1'b0;
            w_reg          <= '0;
            bidx_reg       <= '0;
            scan_idx_reg   <= '0;
            chk_vld_reg    <= 1'b0;
            chk_idx_reg    <= '0;
            key_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_picked_reg <= '0;
            out_status_reg <= brp_pkg::STATUS_OK;
        end
        else
        begin
            if (out_valid_reg && rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // generic scan stepping, overridden below on completion
            if (state_reg == ST_LD_SCAN || state_reg == ST_PK_SCAN
                || state_reg == ST_BI_SCAN)
            begin
                if (!scan_hit)
                begin
                    chk_vld_reg <= scan_can_issue;
                    chk_idx_reg <= scan_idx_reg[AW-1:0];
                    if (scan_can_issue)
                    begin
                        scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                    end
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        out_picked_reg <= '0;
                        out_status_reg <= brp_pkg::STATUS_OK;
                        scan_idx_reg   <= '0;
                        chk_vld_reg    <= 1'b0;
                        unique case (req.mode)
                            brp_pkg::MODE_LOAD:
                            begin
                                key_reg <= req.value[PW-1:0];
                                if (count_reg == CNT_W'(MAX_EXCLUDED))
                                begin
                                    out_status_reg <= brp_pkg::STATUS_FULL;
                                    out_valid_reg  <= 1'b1;
                                end
                                else if (req.value >= {1'b0, range_reg})
                                begin
                                    out_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= ST_LD_SCAN;
                                end
                            end
                            brp_pkg::MODE_BUILD:
                            begin
                                built_reg <= 1'b1;
                                if (PW'(count_reg) >= range_reg)
                                begin
                                    bound_reg      <= '0;
                                    out_status_reg <= brp_pkg::STATUS_EMPTY;
                                    out_valid_reg  <= 1'b1;
                                end
                                else
                                begin
                                    bound_reg <= range_reg - PW'(count_reg);
                                    w_reg     <= range_reg - PW'(count_reg);
                                    bidx_reg  <= '0;
                                    state_reg <= ST_BO_RD;
                                end
                            end
                            brp_pkg::MODE_PICK:
                            begin
                                if (!built_reg)
                                begin
                                    out_status_reg <= brp_pkg::STATUS_NOT_BUILT;
                                    out_valid_reg  <= 1'b1;
                                end
                                else if (bound_reg == '0)
                                begin
                                    out_status_reg <= brp_pkg::STATUS_EMPTY;
                                    out_valid_reg  <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= ST_DIV;
                                end
                            end
                            brp_pkg::MODE_CLEAR:
                            begin
                                count_reg     <= '0;
                                bound_reg     <= '0;
                                built_reg     <= 1'b0;
                                out_valid_reg <= 1'b1;
                            end
                            default:
                            begin
                                out_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_LD_SCAN:
                begin
                    if (scan_hit)
                    begin
                        // duplicate: nothing stored
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else if (scan_miss)
                    begin
                        count_reg     <= count_reg + CNT_W'(1);
                        built_reg     <= 1'b0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        key_reg      <= div_rem;
                        scan_idx_reg <= '0;
                        chk_vld_reg  <= 1'b0;
                        state_reg    <= ST_PK_SCAN;
                    end
                end
                ST_PK_SCAN:
                begin
                    // any stored match lies below the bound, so it has a remap
                    if (scan_hit)
                    begin
                        state_reg <= ST_PK_RD;
                    end
                    else if (scan_miss)
                    begin
                        out_picked_reg <= key_reg;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_PK_RD:
                begin
                    out_picked_reg <= rm_rdata;
                    out_valid_reg  <= 1'b1;
                    state_reg      <= ST_IDLE;
                end
                ST_BO_RD:
                begin
                    if (bidx_reg == count_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_BO_CHK;
                    end
                end
                ST_BO_CHK:
                begin
                    if (ev_rdata >= bound_reg)
                    begin
                        bidx_reg  <= bidx_reg + CNT_W'(1);
                        state_reg <= ST_BO_RD;
                    end
                    else
                    begin
                        key_reg      <= w_reg;
                        scan_idx_reg <= '0;
                        chk_vld_reg  <= 1'b0;
                        state_reg    <= ST_BI_SCAN;
                    end
                end
                ST_BI_SCAN:
                begin
                    if (scan_hit)
                    begin
                        // candidate is excluded: try the next one
                        w_reg        <= w_reg + PW'(1);
                        key_reg      <= w_reg + PW'(1);
                        scan_idx_reg <= '0;
                        chk_vld_reg  <= 1'b0;
                    end
                    else if (scan_miss)
                    begin
                        w_reg     <= w_reg + PW'(1);
                        bidx_reg  <= bidx_reg + CNT_W'(1);
                        state_reg <= ST_BO_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (cfg_wr && (paddr[2] == brp_pkg::REG_RANGE_SIZE))
            begin
                range_reg <= pwdata[PW-1:0];
                built_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign rsp.picked = out_picked_reg;
    assign rsp.status = out_status_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == brp_pkg::REG_RANGE_SIZE) ? 32'(range_reg) : 32'd0;

endmodule
`default_nettype wire

/* tb/blacklist_remap_random_pick_unit_test.sv */
module blacklist_remap_random_pick_unit_test;

    localparam int TABLE_DEPTH = 1024;
    localparam int CYCLE_LIMIT = 5000000;
    localparam logic [29:0] TOP30 = 30'h3FFFFFFF;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    brp_pkg::req_t  req = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    brp_pkg::rsp_t  rsp;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [2:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;

    blacklist_remap_random_pick_unit #(.MAX_EXCLUDED(TABLE_DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow copy of the pick unit state
    logic [29:0] banned_vals [TABLE_DEPTH];
    logic [29:0] remap_to    [TABLE_DEPTH];
    logic        remap_ok    [TABLE_DEPTH];
    int unsigned banned_count;
    logic [29:0] draw_bound;
    logic        remap_built;
    logic [29:0] span;

    brp_pkg::rsp_t pending_results[$];
    int   mismatches;
    int   items_sent;
    int   cycles;
    bit   calm;   // no idling on either side while set

    function automatic bit is_banned(int unsigned v);
        for (int unsigned i = 0; i < banned_count; i++)
            if (banned_vals[i] == v)
                return 1'b1;
        return 1'b0;
    endfunction

    // advances the shadow state by one item and returns its result
    function automatic brp_pkg::rsp_t predict_result(brp_pkg::req_t r);
        brp_pkg::rsp_t o;
        int unsigned   w;
        int unsigned   x;
        o = '0;
        case (r.mode)
            brp_pkg::MODE_LOAD:
            begin
                if (banned_count >= TABLE_DEPTH)
                    o.status = brp_pkg::STATUS_FULL;
                else if (r.value < span && !is_banned(r.value))
                begin
                    banned_vals[banned_count] = r.value[29:0];
                    banned_count++;
                    remap_built = 1'b0;
                end
            end
            brp_pkg::MODE_BUILD:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    remap_ok[i] = 1'b0;
                remap_built = 1'b1;
                if (banned_count >= span)
                begin
                    draw_bound = '0;
                    o.status = brp_pkg::STATUS_EMPTY;
                end
                else
                begin
                    draw_bound = span - banned_count;
                    w = draw_bound;
                    for (int unsigned i = 0; i < banned_count; i++)
                    begin
                        if (banned_vals[i] < draw_bound)
                        begin
                            while (w < TOP30 && is_banned(w))
                                w++;
                            remap_to[i] = w[29:0];
                            remap_ok[i] = 1'b1;
                            if (w < TOP30)
                                w++;
                        end
                    end
                end
            end
            brp_pkg::MODE_PICK:
            begin
                if (!remap_built)
                    o.status = brp_pkg::STATUS_NOT_BUILT;
                else if (draw_bound == 0)
                    o.status = brp_pkg::STATUS_EMPTY;
                else
                begin
                    x = r.value % draw_bound;
                    o.picked = x[29:0];
                    for (int unsigned i = 0; i < banned_count; i++)
                        if (remap_ok[i] && banned_vals[i] == x)
                        begin
                            o.picked = remap_to[i];
                            break;
                        end
                end
            end
            default:
            begin
                banned_count = 0;
                draw_bound = '0;
                remap_built = 1'b0;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    remap_ok[i] = 1'b0;
            end
        endcase
        return o;
    endfunction

    // offer one item; a pinned result replaces the predicted one in the queue
    task automatic send_item(input brp_pkg::req_t r, input bit pinned,
                             input brp_pkg::rsp_t fixed);
        brp_pkg::rsp_t p;
        int            gap;
        gap = (!calm && $urandom_range(0, 99) < 34) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        p = predict_result(r);
        pending_results.push_back(pinned ? fixed : p);
        items_sent++;
    endtask

    task automatic send(input logic [1:0] m, input logic [30:0] v);
        brp_pkg::req_t r;
        r.mode = m;
        r.value = v;
        send_item(r, 1'b0, '0);
    endtask

    // wait until the block is idle and all results are in
    task automatic drain();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_span(input logic [31:0] d);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(brp_pkg::REG_RANGE_SIZE) * 3'd4;
        pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        span = d[29:0];
        remap_built = 1'b0;
    endtask

    // result side: random back-pressure, compare against oldest expectation
    always @(posedge clk)
    begin
        brp_pkg::rsp_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item picked=%0d status=%0d",
                             rsp.picked, rsp.status);
            end
            else
            begin
                e = pending_results.pop_front();
                if (rsp.picked !== e.picked || rsp.status !== e.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected picked=%0d status=%0d,",
                                  " got picked=%0d status=%0d"},
                                 e.picked, e.status, rsp.picked, rsp.status);
                end
            end
        end
        rsp_ready <= calm || ($urandom_range(0, 99) >= 34);
    end

    typedef struct {
        bit          reg_wr;   // row writes range_size instead of sending an item
        logic [1:0]  mode;
        logic [30:0] value;
        bit          pinned;
        logic [29:0] picked;
        logic [1:0]  status;
    } row_t;

    // directed rows: starts at range_size 1, then a ten-value range
    row_t directed [] = '{
        '{0, brp_pkg::MODE_PICK,  31'd0,        1, 30'd0, brp_pkg::STATUS_NOT_BUILT},
        '{0, brp_pkg::MODE_BUILD, 31'd0,        1, 30'd0, brp_pkg::STATUS_OK},
        '{0, brp_pkg::MODE_PICK,  31'h7FFFFFFF, 1, 30'd0, brp_pkg::STATUS_OK},
        '{0, brp_pkg::MODE_LOAD,  31'd0,        1, 30'd0, brp_pkg::STATUS_OK},
        '{0, brp_pkg::MODE_PICK,  31'd5,        1, 30'd0, brp_pkg::STATUS_NOT_BUILT},
        '{0, brp_pkg::MODE_BUILD, 31'd0,        1, 30'd0, brp_pkg::STATUS_EMPTY},
        '{0, brp_pkg::MODE_PICK,  31'd3,        1, 30'd0, brp_pkg::STATUS_EMPTY},
        '{0, brp_pkg::MODE_CLEAR, 31'h55555555, 1, 30'd0, brp_pkg::STATUS_OK},
        '{1, brp_pkg::MODE_LOAD,  31'd10,       0, 30'd0, brp_pkg::STATUS_OK},
        '{0, brp_pkg::MODE_LOAD,  31'd3,        0, 30'd0, brp_pkg::STATUS_OK},
        '{0, brp_pkg::MODE_LOAD,  31'd3,        0, 30'd0, brp_pkg::STATUS_OK},
        '{0, brp_pkg::MODE_LOAD,  31'd9,        0, 30'd0, brp_pkg::STATUS_OK},
        '{0, brp_pkg::MODE_LOAD,  31'd10,       0, 30'd0, brp_pkg::STATUS_OK},
        '{0, brp_pkg::MODE_LOAD,  31'h7FFFFFFF, 0, 30'd0, brp_pkg::STATUS_OK},
        '{0, brp_pkg::MODE_LOAD,  31'd1,        0, 30'd0, brp_pkg::STATUS_OK},
        '{0, brp_pkg::MODE_BUILD, 31'h2AAAAAAA, 0, 30'd0, brp_pkg::STATUS_OK},
        '{0, brp_pkg::MODE_PICK,  31'd1,        0, 30'd0, brp_pkg::STATUS_OK},
        '{0, brp_pkg::MODE_PICK,  31'd3,        0, 30'd0, brp_pkg::STATUS_OK},
        '{0, brp_pkg::MODE_PICK,  31'd6,        0, 30'd0, brp_pkg::STATUS_OK},
        '{0, brp_pkg::MODE_PICK,  31'd8,        0, 30'd0, brp_pkg::STATUS_OK},
        '{0, brp_pkg::MODE_PICK,  31'h7FFFFFFF, 0, 30'd0, brp_pkg::STATUS_OK},
        '{0, brp_pkg::MODE_CLEAR, 31'd0,        1, 30'd0, brp_pkg::STATUS_OK},
        '{0, brp_pkg::MODE_PICK,  31'd2,        1, 30'd0, brp_pkg::STATUS_NOT_BUILT}
    };

    initial
    begin
        brp_pkg::req_t r;
        brp_pkg::rsp_t fix;
        int unsigned   v;
        int            n;
        int            sel;
        int            phase;
        banned_count = 0;
        draw_bound = '0;
        remap_built = 1'b0;
        span = 30'd1;
        for (int i = 0; i < TABLE_DEPTH; i++)
            remap_ok[i] = 1'b0;
        mismatches = 0;
        items_sent = 0;
        cycles = 0;
        calm = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
        begin
            if (directed[k].reg_wr)
                write_span({1'b0, directed[k].value});
            else
            begin
                r.mode = directed[k].mode;
                r.value = directed[k].value;
                fix.picked = directed[k].picked;
                fix.status = directed[k].status;
                send_item(r, directed[k].pinned, fix);
            end
        end

        // random phases: new range, small table, build, then picks
        phase = 0;
        while (items_sent < 560)
        begin
            calm = (phase == 2);
            sel = $urandom_range(0, 9);
            case (sel)
                0: write_span(32'd1);
                1: write_span(32'd2);
                2, 3, 4, 5: write_span($urandom_range(3, 40));
                6, 7: write_span($urandom_range(41, 32'h3FFFFFFF));
                8: write_span(32'hFFFFFFFF);
                default: write_span($urandom);
            endcase
            if (banned_count > 20 || $urandom_range(0, 2) == 0)
                send(brp_pkg::MODE_CLEAR, 31'($urandom));
            n = $urandom_range(0, 12);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 99) < 85)
                    v = $urandom_range(0, span - 1);
                else
                    v = $urandom;
                send(brp_pkg::MODE_LOAD, v[30:0]);
            end
            if ($urandom_range(0, 5) == 0)
                send(brp_pkg::MODE_PICK, 31'($urandom));
            if ($urandom_range(0, 9) != 0)
                send(brp_pkg::MODE_BUILD, 31'($urandom));
            n = $urandom_range(5, 25);
            for (int i = 0; i < n; i++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 40 && banned_count > 0)
                begin
                    // aim the draw at a stored value, possibly wrapped
                    v = banned_vals[$urandom_range(0, banned_count - 1)]
                        + draw_bound * $urandom_range(0, 3);
                    send(brp_pkg::MODE_PICK, v[30:0]);
                end
                else if (sel < 90)
                    send(brp_pkg::MODE_PICK, 31'($urandom));
                else
                    send(2'($urandom), 31'($urandom));
            end
            phase++;
        end

        drain();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
